FILE: rtl/nmn_pkg.sv
// ----------------------------------------------------------------------------
// nmn_pkg
// Shared types and constants for the nibble mode negotiator: beat payloads,
// configuration set and outcome codes.
// ----------------------------------------------------------------------------
package nmn_pkg;

   localparam int unsigned POLL_LIMIT_W  = 5;
   localparam int unsigned GRACE_W       = 11;
   localparam int unsigned CSR_DATA_W    = 11;
   localparam int unsigned CSR_INDEX_W   = 1;

   localparam logic [POLL_LIMIT_W-1:0] POLL_LIMIT_RESET  = 5'd20;
   localparam logic [GRACE_W-1:0]      GRACE_TICKS_RESET = 11'd1600;

   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_LIMIT  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRACE_TICKS = 1'd1;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   // wait result and outcome share one encoding
   localparam logic [1:0] OUTCOME_NO_DEVICE = 2'd0;
   localparam logic [1:0] OUTCOME_MET       = 2'd1;
   localparam logic [1:0] OUTCOME_TIMEOUT   = 2'd2;
   localparam logic [1:0] WAIT_CONTINUE     = 2'd0;

   localparam logic [7:0] STAT_MASK1   = 8'h78;
   localparam logic [7:0] STAT_MATCH1  = 8'h38;
   localparam int unsigned STAT_BUSY_BIT = 5;

   localparam int unsigned CTRL_STROBE   = 0;
   localparam int unsigned CTRL_AUTOFEED = 1;
   localparam int unsigned CTRL_SELECTIN = 3;

   typedef struct packed {
      logic       action;
      logic [7:0] mode;
      logic [7:0] ctrl_in;
      logic [7:0] status;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic [7:0] ctrl_out;
      logic       busy_res;
      logic       done_res;
      logic [1:0] outcome;
   } rsp_type;

   typedef struct packed {
      logic [POLL_LIMIT_W-1:0] poll_limit;
      logic [GRACE_W-1:0]      grace_ticks;
   } cfg_type;

endpackage

FILE: rtl/nmn_csr.sv
// ----------------------------------------------------------------------------
// nmn_csr
// Configuration registers: poll limit and grace tick count, write only.
// ----------------------------------------------------------------------------
module nmn_csr
   import nmn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_POLL_LIMIT:  cfg_in.poll_limit  = csr_wdata[POLL_LIMIT_W-1:0];
            CSR_GRACE_TICKS: cfg_in.grace_ticks = csr_wdata[GRACE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_limit  <= POLL_LIMIT_RESET;
         cfg_ff.grace_ticks <= GRACE_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/nmn_core.sv
// ----------------------------------------------------------------------------
// nmn_core
// Negotiation sequencer: phase, line shadows and poll/grace counters, with
// the next result computed from the accepted beat in one pass.
// ----------------------------------------------------------------------------
module nmn_core
   import nmn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp_next
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_WAIT1, PH_GRACE1, PH_STRHI, PH_STRLO, PH_WAIT2, PH_GRACE2
   } phase_type;

   phase_type               phase_ff,  phase_in;
   logic [7:0]              ctrl_ff,   ctrl_in;
   logic [7:0]              data_ff,   data_in;
   logic [POLL_LIMIT_W-1:0] poll_ff,   poll_in;
   logic [GRACE_W-1:0]      grace_ff,  grace_in;

   logic                    first_wait;
   logic                    cond_met;
   logic [POLL_LIMIT_W-1:0] poll_inc;
   logic [POLL_LIMIT_W-1:0] limit;
   logic [1:0]              wait_res;
   logic                    to_grace;
   logic                    done;
   logic [1:0]              res;

   always_comb begin
      first_wait = (phase_ff inside {PH_WAIT1, PH_GRACE1});
      cond_met   = first_wait ? ((req.status & STAT_MASK1) == STAT_MATCH1)
                              : !req.status[STAT_BUSY_BIT];
      poll_inc   = poll_ff + POLL_LIMIT_W'(1);
      limit      = (cfg.poll_limit == '0) ? POLL_LIMIT_W'(1) : cfg.poll_limit;
   end

   // shared poll / grace wait step
   always_comb begin
      wait_res = WAIT_CONTINUE;
      to_grace = 1'b0;
      poll_in  = poll_ff;
      grace_in = grace_ff;
      if (phase_ff inside {PH_WAIT1, PH_WAIT2}) begin
         poll_in = poll_inc;
         if (cond_met) begin
            wait_res = OUTCOME_MET;
         end else if ((poll_inc >= limit) || (poll_inc == '0)) begin
            to_grace = 1'b1;
            grace_in = '0;
         end
      end else if (grace_ff < cfg.grace_ticks) begin
         grace_in = grace_ff + GRACE_W'(1);
      end else begin
         wait_res = cond_met ? OUTCOME_MET : OUTCOME_TIMEOUT;
      end
   end

   logic [POLL_LIMIT_W-1:0] poll_sel;
   logic [GRACE_W-1:0]      grace_sel;

   always_comb begin
      phase_in  = phase_ff;
      ctrl_in   = ctrl_ff;
      data_in   = data_ff;
      poll_sel  = poll_ff;
      grace_sel = grace_ff;
      done      = 1'b0;
      res       = OUTCOME_NO_DEVICE;
      if (req.action == ACT_START) begin
         if (phase_ff == PH_IDLE) begin
            data_in  = req.mode;
            ctrl_in  = req.ctrl_in;
            ctrl_in[CTRL_SELECTIN] = 1'b0;
            ctrl_in[CTRL_AUTOFEED] = 1'b1;
            poll_sel  = '0;
            grace_sel = '0;
            phase_in  = PH_WAIT1;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            PH_WAIT1, PH_GRACE1: begin
               poll_sel  = poll_in;
               grace_sel = grace_in;
               if (to_grace) begin
                  phase_in = PH_GRACE1;
               end
               if (wait_res == OUTCOME_MET) begin
                  ctrl_in[CTRL_STROBE] = 1'b1;
                  phase_in = PH_STRHI;
               end else if (wait_res == OUTCOME_TIMEOUT) begin
                  ctrl_in[CTRL_AUTOFEED] = 1'b0;
                  ctrl_in[CTRL_SELECTIN] = 1'b1;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
                  res      = OUTCOME_NO_DEVICE;
               end
            end
            PH_STRHI: begin
               ctrl_in[CTRL_STROBE] = 1'b0;
               phase_in = PH_STRLO;
            end
            PH_STRLO: begin
               ctrl_in[CTRL_AUTOFEED] = 1'b0;
               poll_sel  = '0;
               grace_sel = '0;
               phase_in  = PH_WAIT2;
            end
            PH_WAIT2, PH_GRACE2: begin
               poll_sel  = poll_in;
               grace_sel = grace_in;
               if (to_grace) begin
                  phase_in = PH_GRACE2;
               end
               if (wait_res != WAIT_CONTINUE) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
                  res      = wait_res;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ctrl_ff  <= '0;
         data_ff  <= '0;
         poll_ff  <= '0;
         grace_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         ctrl_ff  <= ctrl_in;
         data_ff  <= data_in;
         poll_ff  <= poll_sel;
         grace_ff <= grace_sel;
      end
   end

   always_comb begin
      rsp_next.data_out = data_in;
      rsp_next.ctrl_out = ctrl_in;
      rsp_next.busy_res = (phase_in != PH_IDLE);
      rsp_next.done_res = done;
      rsp_next.outcome  = done ? res : OUTCOME_NO_DEVICE;
   end

endmodule

FILE: rtl/nibble_mode_negotiator.sv
// ----------------------------------------------------------------------------
// nibble_mode_negotiator
// Host side nibble mode negotiation sequencer with a registered result beat.
// ----------------------------------------------------------------------------
// the response beat of an accepted request beat is registered and presented in the next cycle
// throughput: one beat per cycle while not stalled, one response per request
// a held response stalls requests only while the response side stalls
// reset: synchronous, clears the sequencer to idle and the lines to zero,
// and loads the default poll limit and grace tick count
module nibble_mode_negotiator
   import nmn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   rsp_type rsp_next;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    step_en;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign step_en   = req_valid && !req_stall;

   nmn_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nmn_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .req      (req_data),
      .cfg      (cfg),
      .rsp_next (rsp_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (step_en) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response beat payload
   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
